FILE: hdl/swsr_pkg.sv
// shared types and constants of the stop-and-wait sender with rto estimator
package swsr_pkg;

  // field widths
  localparam int SEQ_W   = 32;
  localparam int WND_W   = 32;
  localparam int RTT_W   = 24;
  localparam int RTO_W   = 27;
  localparam int SIZE_W  = 16;
  localparam int BYTES_W = 48;
  localparam int CNT_W   = 32;
  localparam int DUP_W   = 3;
  localparam int CFG_W   = 48;
  localparam int IDX_W   = 2;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] CFG_INITIAL_WINDOW = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TOTAL_BYTES    = 2'd1;
  localparam logic [IDX_W-1:0] CFG_INITIAL_RTO    = 2'd2;

  // register reset values
  localparam logic [WND_W-1:0] RESET_WINDOW = 32'd1;
  localparam logic [RTO_W-1:0] RESET_RTO    = 27'd1000000;

  // estimator and counter limits
  localparam logic [RTT_W-1:0] MIN_DEV_US    = 24'd10000;
  localparam logic [DUP_W-1:0] FAST_RTX_DUPS = 3'd3;
  localparam logic [DUP_W-1:0] DUP_MAX       = 3'd7;

  // request kinds
  localparam logic ACT_ACK     = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // outcome codes
  localparam logic [2:0] OUT_ADVANCED = 3'd0;
  localparam logic [2:0] OUT_DUP      = 3'd1;
  localparam logic [2:0] OUT_FAST_RTX = 3'd2;
  localparam logic [2:0] OUT_STRAY    = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT  = 3'd4;

  // one request as held in the input register
  typedef struct packed {
    logic              action;
    logic [SEQ_W-1:0]  ack_seq;
    logic [WND_W-1:0]  recv_wnd;
    logic [RTT_W-1:0]  rtt_us;
    logic [SIZE_W-1:0] payload_size;
  } req_t;

  // rtt estimator state
  typedef struct packed {
    logic [RTT_W-1:0] srtt;
    logic [RTT_W-1:0] dev;
  } est_t;

endpackage

FILE: hdl/stop_and_wait_sender_rto.sv
// top level: stop-and-wait sender state with rtt estimator and result register
// Each request (an acknowledgement or a retransmission timer expiry) is taken into
// an input register and processed against the sender state in a single pass, the
// result landing in an output register; a result-side stall keeps it waiting in the
// input register. The block takes one request every cycle while the result side
// keeps up. The longest path is the estimator: the 1/8 srtt smoothing, the 1/4
// deviation smoothing and the timeout sum. Writing initial_window or initial_rto_us
// also reloads the current window or timeout; configuration is to be written by the
// user only while no request is in flight, and the block itself does not enforce it.
module stop_and_wait_sender_rto (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [31:0] ack_seq,
  input  logic [31:0] recv_wnd,
  input  logic [23:0] rtt_us,
  input  logic [15:0] payload_size,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  outcome,
  output logic [31:0] base_seq,
  output logic [26:0] rto_us,
  output logic [31:0] effective_window,
  output logic        transfer_done,
  output logic [31:0] timeout_total,
  output logic [31:0] fast_rtx_total
);
  import swsr_pkg::*;

  req_t              req_in;
  req_t              hold;
  logic              hold_valid;
  logic              take;
  logic              fire;

  // configuration registers
  logic [BYTES_W-1:0] total_bytes;

  // sender state
  logic [SEQ_W-1:0]   base_number;
  est_t               est;
  logic [RTO_W-1:0]   timeout_value;
  logic [DUP_W-1:0]   duplicate_count;
  logic [WND_W-1:0]   window_now;
  logic [BYTES_W-1:0] acked_bytes;
  logic [CNT_W-1:0]   timeout_counter;
  logic [CNT_W-1:0]   fast_rtx_counter;
  logic               done_flag;

  // next state
  logic [SEQ_W-1:0]   base_number_next;
  est_t               est_next;
  est_t               est_calc;
  logic [RTO_W-1:0]   rto_calc;
  logic [RTO_W-1:0]   timeout_value_next;
  logic [DUP_W-1:0]   duplicate_count_next;
  logic [WND_W-1:0]   window_now_next;
  logic [BYTES_W-1:0] acked_bytes_next;
  logic [BYTES_W:0]   acked_sum;
  logic [CNT_W-1:0]   timeout_counter_next;
  logic [CNT_W-1:0]   fast_rtx_counter_next;
  logic               done_flag_next;
  logic [2:0]         outcome_next;
  logic [SEQ_W-1:0]   base_plus_one;
  logic               new_ack;
  logic               dup_ack;

  // request payload as one word
  always_comb begin
    req_in.action       = action;
    req_in.ack_seq      = ack_seq;
    req_in.recv_wnd     = recv_wnd;
    req_in.rtt_us       = rtt_us;
    req_in.payload_size = payload_size;
  end

  swsr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_in     (req_in),
    .take       (take),
    .hold_valid (hold_valid),
    .hold       (hold)
  );

  // the result register frees when empty or when its result is taken
  assign take = ~res_valid | ~res_stall;
  assign fire = hold_valid & take;

  swsr_rto_calc u_rto_calc (
    .est      (est),
    .first    (base_number == '0),
    .rtt      (hold.rtt_us),
    .est_next (est_calc),
    .rto_next (rto_calc)
  );

  // classify the held request
  assign base_plus_one = base_number + 1'b1;
  assign new_ack = (hold.action == ACT_ACK) && (hold.ack_seq == base_plus_one);
  assign dup_ack = (hold.action == ACT_ACK) && (hold.ack_seq == base_number);
  assign acked_sum = {1'b0, acked_bytes} + {{(BYTES_W+1-SIZE_W){1'b0}}, hold.payload_size};

  // next sender state for the held request
  always_comb begin
    base_number_next      = base_number;
    est_next              = est;
    timeout_value_next    = timeout_value;
    duplicate_count_next  = duplicate_count;
    window_now_next       = window_now;
    acked_bytes_next      = acked_bytes;
    timeout_counter_next  = timeout_counter;
    fast_rtx_counter_next = fast_rtx_counter;
    done_flag_next        = done_flag;
    outcome_next          = OUT_STRAY;
    if (hold.action == ACT_TIMEOUT) begin
      if (timeout_counter != '1) begin
        timeout_counter_next = timeout_counter + 1'b1;
      end
      outcome_next = OUT_TIMEOUT;
    end else if (new_ack) begin
      base_number_next     = hold.ack_seq;
      duplicate_count_next = '0;
      if (hold.recv_wnd < window_now) begin
        window_now_next = (hold.recv_wnd == '0) ? RESET_WINDOW : hold.recv_wnd;
      end
      est_next           = est_calc;
      timeout_value_next = rto_calc;
      acked_bytes_next   = acked_sum[BYTES_W] ? '1 : acked_sum[BYTES_W-1:0];
      if (acked_bytes_next >= total_bytes) begin
        done_flag_next = 1'b1;
      end
      outcome_next = OUT_ADVANCED;
    end else if (dup_ack) begin
      if (duplicate_count < DUP_MAX) begin
        duplicate_count_next = duplicate_count + 1'b1;
      end
      // fast retransmit only on the rise to three
      if (duplicate_count_next == FAST_RTX_DUPS) begin
        outcome_next = OUT_FAST_RTX;
        if (fast_rtx_counter != '1) begin
          fast_rtx_counter_next = fast_rtx_counter + 1'b1;
        end
      end else begin
        outcome_next = OUT_DUP;
      end
    end
  end

  // sender state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes      <= '0;
      base_number      <= '0;
      est              <= '0;
      timeout_value    <= RESET_RTO;
      duplicate_count  <= '0;
      window_now       <= RESET_WINDOW;
      acked_bytes      <= '0;
      timeout_counter  <= '0;
      fast_rtx_counter <= '0;
      done_flag        <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_INITIAL_WINDOW: begin
          window_now <= (cfg_data[WND_W-1:0] == '0) ? RESET_WINDOW : cfg_data[WND_W-1:0];
        end
        CFG_TOTAL_BYTES: begin
          total_bytes <= cfg_data[BYTES_W-1:0];
        end
        CFG_INITIAL_RTO: begin
          timeout_value <= cfg_data[RTO_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (fire) begin
      base_number      <= base_number_next;
      est              <= est_next;
      timeout_value    <= timeout_value_next;
      duplicate_count  <= duplicate_count_next;
      window_now       <= window_now_next;
      acked_bytes      <= acked_bytes_next;
      timeout_counter  <= timeout_counter_next;
      fast_rtx_counter <= fast_rtx_counter_next;
      done_flag        <= done_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= hold_valid;
    end
    if (fire) begin
      outcome          <= outcome_next;
      base_seq         <= base_number_next;
      rto_us           <= timeout_value_next;
      effective_window <= window_now_next;
      transfer_done    <= done_flag_next;
      timeout_total    <= timeout_counter_next;
      fast_rtx_total   <= fast_rtx_counter_next;
    end
  end

endmodule

FILE: hdl/swsr_in_reg.sv
// input register stage that holds one request until the result stage takes it
module swsr_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  swsr_pkg::req_t req_in,
  input  logic          take,
  output logic          hold_valid,
  output swsr_pkg::req_t hold
);
  import swsr_pkg::*;

  // stall only when the held request cannot move on this cycle
  assign req_stall = hold_valid & ~take;

  // valid flag and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      hold <= req_in;
    end
  end

endmodule

FILE: hdl/swsr_rto_calc.sv
// smoothed rtt, deviation and timeout update for one new acknowledgement
module swsr_rto_calc (
  input  swsr_pkg::est_t                  est,
  input  logic                            first,
  input  logic [swsr_pkg::RTT_W-1:0]      rtt,
  output swsr_pkg::est_t                  est_next,
  output logic [swsr_pkg::RTO_W-1:0]      rto_next
);
  import swsr_pkg::*;

  logic [RTT_W+3:0]  srtt_sum;
  logic [RTT_W-1:0]  srtt_smooth;
  logic [RTT_W-1:0]  diff;
  logic [RTT_W+2:0]  dev_sum;
  logic [RTT_W-1:0]  dev_smooth;
  logic [RTT_W-1:0]  dev_floor;
  logic [RTO_W:0]    rto_sum;

  // srtt gain of 1/8: (7*srtt + r) >> 3, result never exceeds max of inputs
  assign srtt_sum    = ({4'd0, est.srtt} << 3) - {4'd0, est.srtt} + {4'd0, rtt};
  assign srtt_smooth = srtt_sum[RTT_W+2:3];

  // deviation gain of 1/4 against the new srtt
  assign diff       = (rtt >= srtt_smooth) ? (rtt - srtt_smooth) : (srtt_smooth - rtt);
  assign dev_sum    = ({3'd0, est.dev} << 1) + {3'd0, est.dev} + {3'd0, diff};
  assign dev_smooth = dev_sum[RTT_W+1:2];

  // first sample loads srtt directly and keeps the deviation
  always_comb begin
    if (first) begin
      est_next.srtt = rtt;
      est_next.dev  = est.dev;
    end else begin
      est_next.srtt = srtt_smooth;
      est_next.dev  = dev_smooth;
    end
  end

  // timeout = srtt + 4 * max(dev, 10 ms)
  assign dev_floor = (est_next.dev > MIN_DEV_US) ? est_next.dev : MIN_DEV_US;
  assign rto_sum   = {4'd0, est_next.srtt} + ({4'd0, dev_floor} << 2);
  assign rto_next  = rto_sum[RTO_W-1:0];

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// testbench of the stop-and-wait sender: directed table, then randomised phases, checked in order
module tb_top;
  import swsr_pkg::*;

  // sender status as reported per request
  typedef struct packed {
    logic [2:0]  outcome;
    logic [31:0] base;
    logic [26:0] rto;
    logic [31:0] window;
    logic        done;
    logic [31:0] timeouts;
    logic [31:0] fast_rtx;
  } status_t;

  // one line of the directed table; typed rows carry the status read off by hand
  typedef struct packed {
    bit      typed;
    req_t    req;
    status_t want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic        action;
  logic [31:0] ack_seq;
  logic [31:0] recv_wnd;
  logic [23:0] rtt_us;
  logic [15:0] payload_size;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  outcome;
  logic [31:0] base_seq;
  logic [26:0] rto_us;
  logic [31:0] effective_window;
  logic        transfer_done;
  logic [31:0] timeout_total;
  logic [31:0] fast_rtx_total;

  // sender state as predicted
  logic [31:0] snd_base;
  logic [23:0] snd_srtt;
  logic [23:0] snd_dev;
  logic [26:0] snd_rto;
  logic [2:0]  snd_dups;
  logic [31:0] snd_window;
  logic [47:0] snd_acked;
  logic [31:0] snd_timeouts;
  logic [31:0] snd_fast_rtx;
  logic        snd_done;
  logic [47:0] snd_total;

  status_t expected_status[$];
  int      mismatches = 0;
  bit      calm = 0;
  bit      squeeze = 0;
  bit      squeezed = 0;

  // directed requests, starting from initial_window 1, total 100000, rto 1000000
  dir_row_t dir_rows [21] = '{
    '{1'b1, '{ACT_TIMEOUT, 32'd0, 32'd0, 24'd0, 16'd0},
      '{OUT_TIMEOUT, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd0}},
    '{1'b1, '{ACT_ACK, 32'hFFFFFFFF, 32'd0, 24'd0, 16'd0},
      '{OUT_STRAY, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd0}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd0}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'd0, 24'd0, 16'd0},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd0}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'h55555555, 24'h555555, 16'h5555},
      '{OUT_FAST_RTX, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'hAAAAAAAA, 24'hAAAAAA, 16'hAAAA},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'd1, 24'd1, 16'd1},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'd7, 24'd7, 16'd7},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'd3, 24'd3, 16'd3},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd0, 32'd2, 24'd2, 16'd2},
      '{OUT_DUP, 32'd0, 27'd1000000, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b1, '{ACT_ACK, 32'd1, 32'hFFFFFFFF, 24'hFFFFFF, 16'hFFFF},
      '{OUT_ADVANCED, 32'd1, 27'd16817215, 32'd1, 1'b0, 32'd1, 32'd1}},
    '{1'b0, '{ACT_ACK, 32'd2, 32'd0, 24'd0, 16'd0}, '0},
    '{1'b0, '{ACT_ACK, 32'd2, 32'd9, 24'd100, 16'd10}, '0},
    '{1'b0, '{ACT_TIMEOUT, 32'd0, 32'd0, 24'd0, 16'd0}, '0},
    '{1'b0, '{ACT_ACK, 32'd2, 32'd5, 24'd5, 16'd5}, '0},
    '{1'b0, '{ACT_ACK, 32'd2, 32'd5, 24'd5, 16'd5}, '0},
    '{1'b0, '{ACT_ACK, 32'd3, 32'd0, 24'hFFFFFF, 16'hFFFF}, '0},
    '{1'b0, '{ACT_ACK, 32'd7, 32'd4, 24'd4, 16'd4}, '0},
    '{1'b0, '{ACT_ACK, 32'd4, 32'd4, 24'd10000, 16'd1}, '0},
    '{1'b0, '{ACT_ACK, 32'd4, 32'h80000000, 24'h800000, 16'h8000}, '0},
    '{1'b0, '{ACT_ACK, 32'd5, 32'h7FFFFFFF, 24'h7FFFFF, 16'h7FFF}, '0}
  };

  stop_and_wait_sender_rto u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .action           (action),
    .ack_seq          (ack_seq),
    .recv_wnd         (recv_wnd),
    .rtt_us           (rtt_us),
    .payload_size     (payload_size),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .outcome          (outcome),
    .base_seq         (base_seq),
    .rto_us           (rto_us),
    .effective_window (effective_window),
    .transfer_done    (transfer_done),
    .timeout_total    (timeout_total),
    .fast_rtx_total   (fast_rtx_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL stop_and_wait_sender_rto");
    $finish;
  end

  // sender state after one request, with its status
  task automatic advance_sender(input req_t r, output status_t s);
    logic [27:0] srtt_sum;
    logic [26:0] dev_sum;
    logic [23:0] diff;
    logic [23:0] dev_floor;
    logic [48:0] bytes_sum;
    logic [2:0]  code;
    bit          first;
    if (r.action == ACT_TIMEOUT) begin
      if (snd_timeouts != 32'hFFFFFFFF) snd_timeouts = snd_timeouts + 1;
      code = OUT_TIMEOUT;
    end else if (r.ack_seq == snd_base + 32'd1) begin
      first = (snd_base == 32'd0);
      snd_base = r.ack_seq;
      snd_dups = 3'd0;
      if (r.recv_wnd < snd_window) snd_window = (r.recv_wnd == 32'd0) ? 32'd1 : r.recv_wnd;
      if (first) begin
        snd_srtt = r.rtt_us;
      end else begin
        // 7/8 old plus 1/8 new, then 3/4 old deviation plus 1/4 new error
        srtt_sum = 28'(snd_srtt) * 28'd7 + 28'(r.rtt_us);
        snd_srtt = srtt_sum[26:3];
        diff = (r.rtt_us >= snd_srtt) ? r.rtt_us - snd_srtt : snd_srtt - r.rtt_us;
        dev_sum = 27'(snd_dev) * 27'd3 + 27'(diff);
        snd_dev = dev_sum[25:2];
      end
      dev_floor = (snd_dev > MIN_DEV_US) ? snd_dev : MIN_DEV_US;
      snd_rto = 27'(snd_srtt) + {1'b0, dev_floor, 2'b00};
      bytes_sum = 49'(snd_acked) + 49'(r.payload_size);
      snd_acked = bytes_sum[48] ? 48'hFFFFFFFFFFFF : bytes_sum[47:0];
      if (snd_acked >= snd_total) snd_done = 1'b1;
      code = OUT_ADVANCED;
    end else if (r.ack_seq == snd_base) begin
      if (snd_dups < DUP_MAX) snd_dups = snd_dups + 3'd1;
      if (snd_dups == FAST_RTX_DUPS) begin
        code = OUT_FAST_RTX;
        if (snd_fast_rtx != 32'hFFFFFFFF) snd_fast_rtx = snd_fast_rtx + 1;
      end else begin
        code = OUT_DUP;
      end
    end else begin
      code = OUT_STRAY;
    end
    s = '{code, snd_base, snd_rto, snd_window, snd_done, snd_timeouts, snd_fast_rtx};
  endtask

  // offer one request, wait for it to be taken, then note what it should produce
  task automatic offer(input req_t r, input bit typed, input status_t typed_want);
    status_t s;
    while (!calm && $urandom_range(99) < 31) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid    <= 1'b1;
    action       <= r.action;
    ack_seq      <= r.ack_seq;
    recv_wnd     <= r.recv_wnd;
    rtt_us       <= r.rtt_us;
    payload_size <= r.payload_size;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    advance_sender(r, s);
    expected_status.push_back(typed ? typed_want : s);
    @(negedge clk);
  endtask

  // stop offering and wait until every status has come back
  task automatic settle(input int pause);
    req_valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (pause) @(negedge clk);
  endtask

  // write all three registers while idle
  task automatic apply_settings(input logic [31:0] win, input logic [47:0] total,
                                input logic [26:0] rto);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_INITIAL_WINDOW;
    cfg_data  <= {16'd0, win};
    @(negedge clk);
    cfg_index <= CFG_TOTAL_BYTES;
    cfg_data  <= total;
    @(negedge clk);
    cfg_index <= CFG_INITIAL_RTO;
    cfg_data  <= {21'd0, rto};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    snd_window = (win == 32'd0) ? 32'd1 : win;
    snd_total  = total;
    snd_rto    = rto;
  endtask

  // compare one field
  task automatic flag(input string what, input logic [63:0] want_v, input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side: random stalls, a calm stretch, and one long hold-off
  initial begin : result_side
    int unsigned hold;
    hold = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        hold = 120;
      end
      if (hold != 0) begin
        hold--;
        res_stall <= 1'b1;
      end else if (calm || rst) begin
        res_stall <= 1'b0;
      end else begin
        res_stall <= ($urandom_range(99) < 31);
      end
    end
  end

  // status checker
  always @(posedge clk) begin : check_status
    status_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_status.size() == 0) begin
        $display("%0t ns: unexpected status, expected none, actual outcome %0d base %0h",
                 $time, outcome, base_seq);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        flag("outcome", 64'(want.outcome), 64'(outcome));
        flag("base_seq", 64'(want.base), 64'(base_seq));
        flag("rto_us", 64'(want.rto), 64'(rto_us));
        flag("effective_window", 64'(want.window), 64'(effective_window));
        flag("transfer_done", 64'(want.done), 64'(transfer_done));
        flag("timeout_total", 64'(want.timeouts), 64'(timeout_total));
        flag("fast_rtx_total", 64'(want.fast_rtx), 64'(fast_rtx_total));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    req_t        r;
    int unsigned pick;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_index    = CFG_INITIAL_WINDOW;
    cfg_data     = '0;
    req_valid    = 1'b0;
    action       = ACT_ACK;
    ack_seq      = '0;
    recv_wnd     = '0;
    rtt_us       = '0;
    payload_size = '0;
    snd_base     = '0;
    snd_srtt     = '0;
    snd_dev      = '0;
    snd_rto      = RESET_RTO;
    snd_dups     = '0;
    snd_window   = RESET_WINDOW;
    snd_acked    = '0;
    snd_timeouts = '0;
    snd_fast_rtx = '0;
    snd_done     = 1'b0;
    snd_total    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    apply_settings(32'd1, 48'd100000, 27'd1000000);
    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    // random phases, each under its own register settings
    for (int phase = 0; phase < 6; phase++) begin
      settle(4);
      case (phase)
        0: apply_settings(32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 27'h7FFFFFF);
        1: apply_settings(32'd1, 48'd0, 27'd0);
        default: apply_settings(($urandom == 0) ? 32'd1 : $urandom,
                                48'({$urandom, $urandom}),
                                27'($urandom));
      endcase
      calm = (phase == 3);
      for (int n = 0; n < 320; n++) begin
        if (phase == 4 && n == 100) squeeze = 1'b1;
        r.action = ($urandom_range(99) < 12) ? ACT_TIMEOUT : ACT_ACK;
        // mostly the next ack or a repeat of the current one, some strays
        pick = $urandom_range(99);
        if (pick < 50)      r.ack_seq = snd_base + 32'd1;
        else if (pick < 80) r.ack_seq = snd_base;
        else                r.ack_seq = $urandom;
        pick = $urandom_range(99);
        if (pick < 50)      r.recv_wnd = $urandom;
        else if (pick < 80) r.recv_wnd = $urandom_range(64, 0);
        else if (pick < 90) r.recv_wnd = 32'd0;
        else                r.recv_wnd = 32'hFFFFFFFF;
        pick = $urandom_range(99);
        if (pick < 40)      r.rtt_us = 24'($urandom_range(200000, 0));
        else if (pick < 80) r.rtt_us = 24'($urandom);
        else if (pick < 90) r.rtt_us = 24'd0;
        else                r.rtt_us = 24'hFFFFFF;
        r.payload_size = 16'($urandom);
        offer(r, 1'b0, '0);
      end
    end
    calm = 1'b0;

    // drain and report
    settle(10);
    if (mismatches == 0) begin
      $display("PASS stop_and_wait_sender_rto");
    end else begin
      $display("FAIL stop_and_wait_sender_rto");
    end
    $finish;
  end

endmodule
